@@ rtl/core/mdsr_pkg.sv @@
// ----------------------------------------------------------------------------
// Message dedupe and snooze router package
// Shared request and response types, codes and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mdsr_pkg;

  localparam int unsigned KEY_WIDTH    = 64;
  localparam int unsigned HANDLE_WIDTH = 16;
  localparam int unsigned TIME_WIDTH   = 48;
  localparam int unsigned DELAY_WIDTH  = 32;

  localparam logic [DELAY_WIDTH-1:0] DELAY_RESET = 32'd900_000_000;

  typedef enum logic [1:0] {
    CMD_ARRIVE = 2'd0,
    CMD_SNOOZE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_OFF     = 3'd0,
    KIND_DUP     = 3'd1,
    KIND_SHOWN   = 3'd2,
    KIND_SNOOZED = 3'd3,
    KIND_NOCACHE = 3'd4,
    KIND_REFIRE  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    CUE_NONE = 2'd0,
    CUE_LOW  = 2'd1,
    CUE_HIGH = 2'd2
  } cue_e;

  typedef struct packed {
    logic [1:0]              command;
    logic [KEY_WIDTH-1:0]    message_key;
    logic [HANDLE_WIDTH-1:0] payload_handle;
    logic                    channel_enabled;
    logic                    from_starred;
    logic                    wants_reply;
    logic                    high_priority;
    logic                    quiet;
    logic [TIME_WIDTH-1:0]   now_us;
  } req_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic                    now_card;
    logic                    dim_toast;
    logic [1:0]              audio_cue;
    logic                    overflow;
    logic [KEY_WIDTH-1:0]    out_key;
    logic [HANDLE_WIDTH-1:0] out_handle;
    logic                    last;
  } rsp_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]    key;
    logic [HANDLE_WIDTH-1:0] handle;
    logic [TIME_WIDTH-1:0]   deadline;
  } snz_ent_t;

endpackage

`default_nettype wire

@@ rtl/core/mdsr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mdsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/core/message_dedupe_snooze_router_core.sv @@
// ----------------------------------------------------------------------------
// Message dedupe and snooze router core
// Routes arrivals, drops duplicates and keeps a list of snoozed messages.
// ----------------------------------------------------------------------------
// One request is worked on at a time; the rate is set by walking the key ring and
// the snooze list through their single read ports. Reset clears the ring's valid
// flags at once; no clearing pass is needed.
`default_nettype none

module message_dedupe_snooze_router_core #(
  parameter int unsigned SEEN_DEPTH   = 32,
  parameter int unsigned SNOOZE_DEPTH = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire mdsr_pkg::req_t                     in_req_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output mdsr_pkg::rsp_t                          out_rsp_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [mdsr_pkg::DELAY_WIDTH-1:0]   cfg_wdata_i
);

  import mdsr_pkg::*;

  localparam int unsigned SAW = $clog2(SEEN_DEPTH);
  localparam int unsigned NAW = (SNOOZE_DEPTH > 1) ? $clog2(SNOOZE_DEPTH) : 1;
  localparam int unsigned NCW = $clog2(SNOOZE_DEPTH + 1);
  localparam int unsigned EW  = $bits(snz_ent_t);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_DUP    = 11'b000_0000_0010,
    ST_SHOW   = 11'b000_0000_0100,
    ST_RESULT = 11'b000_0000_1000,
    ST_SHIFT  = 11'b000_0001_0000,
    ST_SNZWR  = 11'b000_0010_0000,
    ST_DUE    = 11'b000_0100_0000,
    ST_FIRE   = 11'b000_1000_0000,
    ST_CLR    = 11'b001_0000_0000,
    ST_EMIT   = 11'b010_0000_0000,
    ST_PACK   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   ph_q, ph_d;
  logic [SAW-1:0] sidx_q, sidx_d;
  logic [SAW-1:0] head_q, head_d;
  logic [SEEN_DEPTH-1:0] seen_vld_q, seen_vld_d;
  logic [NCW-1:0] nidx_q, nidx_d;
  logic [NCW-1:0] wptr_q, wptr_d;
  logic [NCW-1:0] cnt_q, cnt_d;
  logic [NCW-1:0] nidx_dec;
  logic [SNOOZE_DEPTH-1:0] due_q, due_d;
  logic cvld_q, cvld_d;
  logic [KEY_WIDTH-1:0] ckey_q, ckey_d;
  logic [HANDLE_WIDTH-1:0] chdl_q, chdl_d;
  logic [KEY_WIDTH-1:0] fkey_q, fkey_d;
  logic [HANDLE_WIDTH-1:0] fhdl_q, fhdl_d;
  logic [DELAY_WIDTH-1:0] delay_q;
  req_t req_q, req_d;
  rsp_t res_q, res_d;
  rsp_t out_q, out_d;
  logic out_vld_q, out_vld_d;
  logic out_free, accept, card, below_due;

  logic            seen_we;
  logic [SAW-1:0]  seen_waddr, seen_raddr;
  logic [KEY_WIDTH-1:0] seen_rdata;
  logic            snz_we;
  logic [NAW-1:0]  snz_waddr, snz_raddr;
  snz_ent_t        snz_wdata, snz_rdata;
  logic [EW-1:0]   snz_rdata_raw;

  mdsr_ram #(.WIDTH(KEY_WIDTH), .DEPTH(SEEN_DEPTH)) u_seen_ram (
    .clk_i   (clk_i),
    .we_i    (seen_we),
    .waddr_i (seen_waddr),
    .wdata_i (req_q.message_key),
    .raddr_i (seen_raddr),
    .rdata_o (seen_rdata)
  );

  mdsr_ram #(.WIDTH(EW), .DEPTH(SNOOZE_DEPTH)) u_snz_ram (
    .clk_i   (clk_i),
    .we_i    (snz_we),
    .waddr_i (snz_waddr),
    .wdata_i (snz_wdata),
    .raddr_i (snz_raddr),
    .rdata_o (snz_rdata_raw)
  );

  assign snz_rdata   = snz_ent_t'(snz_rdata_raw);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;
  assign nidx_dec    = nidx_q - 1'b1;
  assign card        = req_q.from_starred || req_q.wants_reply || req_q.high_priority;
  assign seen_raddr  = sidx_q;
  assign seen_waddr  = head_q;

  always_comb begin
    below_due = 1'b0;
    for (int j = 0; j < SNOOZE_DEPTH; j++) begin
      if ((NCW'(j) < nidx_q) && due_q[j]) begin
        below_due = 1'b1;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    ph_d       = ph_q;
    sidx_d     = sidx_q;
    head_d     = head_q;
    seen_vld_d = seen_vld_q;
    nidx_d     = nidx_q;
    wptr_d     = wptr_q;
    cnt_d      = cnt_q;
    due_d      = due_q;
    cvld_d     = cvld_q;
    ckey_d     = ckey_q;
    chdl_d     = chdl_q;
    fkey_d     = fkey_q;
    fhdl_d     = fhdl_q;
    req_d      = req_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && out_stall_i;
    seen_we    = 1'b0;
    snz_we     = 1'b0;
    snz_waddr  = wptr_q[NAW-1:0];
    snz_raddr  = nidx_q[NAW-1:0];
    snz_wdata  = snz_rdata;

    case (state_q)
      ST_IDLE: begin
        ph_d   = 1'b0;
        sidx_d = '0;
        nidx_d = '0;
        res_d  = '0;
        res_d.last = 1'b1;
        if (accept) begin
          req_d = in_req_i;
          case (in_req_i.command)
            CMD_ARRIVE: begin
              if (!in_req_i.channel_enabled) begin
                res_d.kind = KIND_OFF;
                state_d    = ST_RESULT;
              end else if (in_req_i.message_key == '0) begin
                state_d = ST_SHOW;
              end else begin
                state_d = ST_DUP;
              end
            end
            CMD_SNOOZE: begin
              if (!cvld_q) begin
                res_d.kind = KIND_NOCACHE;
                state_d    = ST_RESULT;
              end else if (cnt_q == NCW'(SNOOZE_DEPTH)) begin
                state_d = ST_SHIFT;
              end else begin
                wptr_d  = cnt_q;
                state_d = ST_SNZWR;
              end
            end
            CMD_TICK: begin
              if (!in_req_i.quiet && (cnt_q != '0)) begin
                due_d   = '0;
                state_d = ST_DUE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DUP: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          if (seen_vld_q[sidx_q] && (seen_rdata == req_q.message_key)) begin
            res_d.kind = KIND_DUP;
            state_d    = ST_RESULT;
          end else if (sidx_q == SAW'(SEEN_DEPTH - 1)) begin
            seen_we            = 1'b1;
            seen_vld_d[head_q] = 1'b1;
            head_d  = (head_q == SAW'(SEEN_DEPTH - 1)) ? '0 : head_q + 1'b1;
            state_d = ST_SHOW;
          end else begin
            sidx_d = sidx_q + 1'b1;
          end
        end
      end
      ST_SHOW: begin
        if (card) begin
          cvld_d = 1'b1;
          ckey_d = req_q.message_key;
          chdl_d = req_q.payload_handle;
        end
        res_d.kind      = KIND_SHOWN;
        res_d.now_card  = card;
        res_d.dim_toast = !card && req_q.quiet;
        res_d.audio_cue = req_q.quiet ? CUE_NONE : (card ? CUE_HIGH : CUE_LOW);
        state_d         = ST_RESULT;
      end
      ST_SHIFT: begin
        snz_raddr = NAW'(nidx_q + 1'b1);
        snz_waddr = nidx_q[NAW-1:0];
        if (!ph_q) begin
          if (nidx_q == NCW'(SNOOZE_DEPTH - 1)) begin
            wptr_d         = nidx_q;
            res_d.overflow = 1'b1;
            state_d        = ST_SNZWR;
          end else begin
            ph_d = 1'b1;
          end
        end else begin
          snz_we = 1'b1;
          ph_d   = 1'b0;
          nidx_d = nidx_q + 1'b1;
        end
      end
      ST_SNZWR: begin
        snz_we             = 1'b1;
        snz_wdata.key      = ckey_q;
        snz_wdata.handle   = chdl_q;
        snz_wdata.deadline = req_q.now_us + TIME_WIDTH'(delay_q);
        cnt_d              = wptr_q + 1'b1;
        res_d.kind         = KIND_SNOOZED;
        state_d            = ST_RESULT;
      end
      ST_DUE: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          due_d[nidx_q[NAW-1:0]] = (snz_rdata.deadline <= req_q.now_us);
          if (nidx_q == cnt_q - 1'b1) begin
            nidx_d  = cnt_q;
            state_d = ST_FIRE;
          end else begin
            nidx_d = nidx_q + 1'b1;
          end
        end
      end
      ST_FIRE: begin
        snz_raddr = nidx_dec[NAW-1:0];
        if (!ph_q) begin
          if (nidx_q == '0) begin
            wptr_d  = '0;
            state_d = ST_PACK;
          end else if (due_q[nidx_dec[NAW-1:0]]) begin
            ph_d = 1'b1;
          end else begin
            nidx_d = nidx_dec;
          end
        end else begin
          ph_d   = 1'b0;
          fkey_d = snz_rdata.key;
          fhdl_d = snz_rdata.handle;
          nidx_d = nidx_dec;
          sidx_d = '0;
          state_d = (snz_rdata.key == '0) ? ST_EMIT : ST_CLR;
        end
      end
      ST_CLR: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          if (seen_vld_q[sidx_q] && (seen_rdata == fkey_q)) begin
            seen_vld_d[sidx_q] = 1'b0;
            state_d            = ST_EMIT;
          end else if (sidx_q == SAW'(SEEN_DEPTH - 1)) begin
            state_d = ST_EMIT;
          end else begin
            sidx_d = sidx_q + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_d            = '0;
          out_d.kind       = KIND_REFIRE;
          out_d.out_key    = fkey_q;
          out_d.out_handle = fhdl_q;
          out_d.last       = !below_due;
          out_vld_d        = 1'b1;
          state_d          = ST_FIRE;
        end
      end
      ST_PACK: begin
        if (!ph_q) begin
          if (nidx_q == cnt_q) begin
            cnt_d   = wptr_q;
            state_d = ST_IDLE;
          end else if (due_q[nidx_q[NAW-1:0]]) begin
            nidx_d = nidx_q + 1'b1;
          end else begin
            ph_d = 1'b1;
          end
        end else begin
          snz_we = 1'b1;
          ph_d   = 1'b0;
          wptr_d = wptr_q + 1'b1;
          nidx_d = nidx_q + 1'b1;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ph_q       <= 1'b0;
      sidx_q     <= '0;
      head_q     <= '0;
      seen_vld_q <= '0;
      nidx_q     <= '0;
      wptr_q     <= '0;
      cnt_q      <= '0;
      due_q      <= '0;
      cvld_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      delay_q    <= DELAY_RESET;
    end else begin
      state_q    <= state_d;
      ph_q       <= ph_d;
      sidx_q     <= sidx_d;
      head_q     <= head_d;
      seen_vld_q <= seen_vld_d;
      nidx_q     <= nidx_d;
      wptr_q     <= wptr_d;
      cnt_q      <= cnt_d;
      due_q      <= due_d;
      cvld_q     <= cvld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        delay_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    out_q  <= out_d;
    ckey_q <= ckey_d;
    chdl_q <= chdl_d;
    fkey_q <= fkey_d;
    fhdl_q <= fhdl_d;
  end

`ifndef SYNTH
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NCW'(SNOOZE_DEPTH))
    else $error("Snooze list count exceeds its depth.");

  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == ST_RESULT || $past(state_q) == ST_EMIT))
    else $error("Result raised outside a result state.");

  a_head_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(head_q) |-> seen_vld_q[$past(head_q)])
    else $error("Ring head advanced without filling its slot.");
`endif

endmodule

`default_nettype wire
